// ===== hdl/hfvd_pkg.sv =====
// shared types, constants and binary16/binary32 arithmetic for the vector distance block
`default_nettype none
package hfvd_pkg;

    localparam int LANE_COUNT  = 8;
    localparam int TREE_LEVELS = $clog2(LANE_COUNT);

    localparam logic [15:0] H_ONE  = 16'h3C00;
    localparam logic [15:0] H_DNAN = 16'h7E00;
    localparam logic [31:0] F_ONE  = 32'h3F80_0000;
    localparam logic [31:0] F_DNAN = 32'h7FC0_0000;
    localparam logic [31:0] F_PINF = 32'h7F80_0000;

    localparam logic [1:0] MODE_L2     = 2'd0;
    localparam logic [1:0] MODE_IP     = 2'd1;
    localparam logic [1:0] MODE_COS    = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_LOAD,
        ST_RED,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic acc;
        logic clr;
        logic l2;
        logic cosine;
    } lane_ctl_t;

    typedef logic [7:0] rs_tab_t [512];

    // reciprocal square root estimate table, indexed by the 9-bit scaled fraction
    function automatic rs_tab_t rs_build();
        rs_tab_t         t;
        longint unsigned x;
        longint unsigned b;
        for (int a = 0; a < 512; a++) begin
            if (a < 128) begin
                t[a] = 8'h00;
            end else begin
                if (a < 256) x = longint'(a) * 2 + 1;
                else x = ((longint'(a >> 1) << 1) + 1) * 2;
                b = 512;
                for (int k = 0; k < 1024; k++) begin
                    if (x * (b + 1) * (b + 1) < (64'd1 << 28)) b = b + 1;
                end
                t[a] = 8'((b + 1) >> 1);
            end
        end
        return t;
    endfunction

    localparam rs_tab_t RS_TABLE = rs_build();

    function automatic logic h_nan(input logic [15:0] v);
        return (v[14:10] == 5'h1F) && (v[9:0] != 10'h0);
    endfunction

    function automatic logic h_snan(input logic [15:0] v);
        return h_nan(v) && !v[9];
    endfunction

    function automatic logic h_inf(input logic [15:0] v);
        return v[14:0] == 15'h7C00;
    endfunction

    function automatic logic h_zero(input logic [15:0] v);
        return v[14:0] == 15'h0000;
    endfunction

    // round sign * mag * 2^-48 to binary16, nearest even
    function automatic logic [15:0] h_round(input logic sign, input logic [80:0] mag);
        int          h;
        int          q;
        int          s;
        int          e;
        logic [11:0] r;
        logic [80:0] mask;
        logic        guard;
        logic        sticky;
        logic [15:0] res;
        h = 0;
        for (int i = 0; i < 81; i++) begin
            if (mag[i]) h = i;
        end
        q = h - 58;
        if (q < -24) q = -24;
        s = q + 48;
        r = 12'(mag >> s);
        guard = mag[s-1];
        mask = (81'(1) << (s - 1)) - 81'(1);
        sticky = (mag & mask) != 81'(0);
        if (guard && (sticky || r[0])) r = r + 12'd1;
        if (r[11]) begin
            r = r >> 1;
            q = q + 1;
        end
        e = q + 25;
        if (mag == 81'(0)) res = {sign, 15'h0000};
        else if (r[10] && e >= 31) res = {sign, 15'h7C00};
        else if (r[10]) res = {sign, 5'(e), r[9:0]};
        else res = {sign, 5'h00, r[9:0]};
        return res;
    endfunction

    // z + x*y with a single rounding
    function automatic logic [15:0] h_fma(input logic [15:0] z, input logic [15:0] x,
                                          input logic [15:0] y);
        logic        sp;
        logic        pinf;
        logic        pzero;
        logic [10:0] mx;
        logic [10:0] my;
        logic [10:0] mz;
        int          ox;
        int          oy;
        int          oz;
        logic [21:0] prod;
        logic [79:0] fa;
        logic [79:0] fb;
        logic [80:0] mag;
        logic        sign;
        logic [15:0] res;
        sp = x[15] ^ y[15];
        pinf = h_inf(x) || h_inf(y);
        pzero = h_zero(x) || h_zero(y);
        mx = {x[14:10] != 5'h00, x[9:0]};
        my = {y[14:10] != 5'h00, y[9:0]};
        mz = {z[14:10] != 5'h00, z[9:0]};
        ox = (x[14:10] == 5'h00) ? 0 : int'(x[14:10]) - 1;
        oy = (y[14:10] == 5'h00) ? 0 : int'(y[14:10]) - 1;
        oz = (z[14:10] == 5'h00) ? 0 : int'(z[14:10]) - 1;
        prod = 22'(mx) * 22'(my);
        fa = 80'(prod) << (ox + oy);
        fb = 80'(mz) << (oz + 24);
        if (sp == z[15]) begin
            mag = {1'b0, fa} + {1'b0, fb};
            sign = sp;
        end else if (fa > fb) begin
            mag = {1'b0, fa - fb};
            sign = sp;
        end else if (fb > fa) begin
            mag = {1'b0, fb - fa};
            sign = z[15];
        end else begin
            mag = 81'(0);
            sign = 1'b0;
        end
        if (h_nan(x) || h_nan(y) || h_nan(z)) begin
            if (h_nan(z) && !h_snan(z) &&
                ((h_inf(x) && h_zero(y)) || (h_zero(x) && h_inf(y)))) res = H_DNAN;
            else if (h_snan(z)) res = z | 16'h0200;
            else if (h_snan(x)) res = x | 16'h0200;
            else if (h_snan(y)) res = y | 16'h0200;
            else if (h_nan(z)) res = z;
            else if (h_nan(x)) res = x;
            else res = y;
        end else if (pinf && pzero) begin
            res = H_DNAN;
        end else if (pinf && h_inf(z) && sp != z[15]) begin
            res = H_DNAN;
        end else if (pinf) begin
            res = {sp, 15'h7C00};
        end else if (h_inf(z)) begin
            res = z;
        end else begin
            res = h_round(sign, mag);
        end
        return res;
    endfunction

    function automatic logic [15:0] h_nan2(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] res;
        if (h_snan(a)) res = a | 16'h0200;
        else if (h_snan(b)) res = b | 16'h0200;
        else if (h_nan(a)) res = a;
        else res = b;
        return res;
    endfunction

    function automatic logic [15:0] h_add(input logic [15:0] a, input logic [15:0] b);
        return (h_nan(a) || h_nan(b)) ? h_nan2(a, b) : h_fma(b, a, H_ONE);
    endfunction

    function automatic logic [15:0] h_sub(input logic [15:0] a, input logic [15:0] b);
        return (h_nan(a) || h_nan(b)) ? h_nan2(a, b) : h_fma(b ^ 16'h8000, a, H_ONE);
    endfunction

    function automatic logic [31:0] h_widen(input logic [15:0] v);
        int          p;
        logic [31:0] res;
        logic [22:0] fr;
        p = 0;
        for (int i = 0; i < 10; i++) begin
            if (v[i]) p = i;
        end
        fr = 23'({v[9:0], 13'h0000} << (10 - p));
        if (v[14:10] == 5'h1F && v[9:0] == 10'h0) res = {v[15], 31'h7F80_0000};
        else if (v[14:10] == 5'h1F) res = {v[15], 31'h7FC0_0000} | {10'h0, v[8:0], 13'h0};
        else if (v[14:10] == 5'h00 && v[9:0] == 10'h0) res = {v[15], 31'h0};
        else if (v[14:10] == 5'h00) res = {v[15], 8'(p + 103), fr};
        else res = {v[15], 8'(v[14:10]) + 8'd112, v[9:0], 13'h0000};
        return res;
    endfunction

    function automatic logic f_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'h0);
    endfunction

    function automatic logic f_snan(input logic [31:0] v);
        return f_nan(v) && !v[22];
    endfunction

    function automatic logic f_inf(input logic [31:0] v);
        return v[30:0] == 31'h7F80_0000;
    endfunction

    function automatic logic f_zero(input logic [31:0] v);
        return v[30:0] == 31'h0;
    endfunction

    // binary32 product; finite non-zero operands here are always normal
    function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic [47:0] p;
        logic [23:0] mant;
        logic [24:0] rnd;
        logic        g;
        logic        st;
        int          e;
        logic [31:0] res;
        s = a[31] ^ b[31];
        p = 48'({1'b1, a[22:0]}) * 48'({1'b1, b[22:0]});
        e = int'(a[30:23]) + int'(b[30:23]) - 127;
        if (p[47]) begin
            mant = p[47:24];
            g = p[23];
            st = p[22:0] != 23'h0;
            e = e + 1;
        end else begin
            mant = p[46:23];
            g = p[22];
            st = p[21:0] != 22'h0;
        end
        rnd = {1'b0, mant} + 25'(g && (st || mant[0]));
        if (rnd[24]) begin
            mant = rnd[24:1];
            e = e + 1;
        end else begin
            mant = rnd[23:0];
        end
        if (f_nan(a) || f_nan(b)) begin
            if (f_snan(a)) res = a | 32'h0040_0000;
            else if (f_snan(b)) res = b | 32'h0040_0000;
            else if (f_nan(a)) res = a;
            else res = b;
        end else if ((f_inf(a) && f_zero(b)) || (f_zero(a) && f_inf(b))) begin
            res = F_DNAN;
        end else if (f_inf(a) || f_inf(b)) begin
            res = {s, 31'h7F80_0000};
        end else if (f_zero(a) || f_zero(b)) begin
            res = {s, 31'h0};
        end else if (e >= 255) begin
            res = {s, 31'h7F80_0000};
        end else if (e <= 0) begin
            res = {s, 31'h0};
        end else begin
            res = {s, 8'(e), mant[22:0]};
        end
        return res;
    endfunction

    // 1 - x in binary32; finite non-zero x is always normal here
    function automatic logic [31:0] f_one_minus(input logic [31:0] x);
        logic        xs;
        logic        a_big;
        logic [26:0] m1;
        logic [26:0] m2;
        logic [26:0] sm;
        logic [26:0] mask;
        logic [27:0] r;
        logic        sbig;
        int          d;
        int          e;
        logic [23:0] mant;
        logic [24:0] rnd;
        logic [31:0] res;
        xs = ~x[31];
        a_big = {8'd127, 23'h0} > x[30:0];
        if (a_big) begin
            m1 = {1'b1, 23'h0, 3'b000};
            m2 = {1'b1, x[22:0], 3'b000};
            e = 127;
            d = 127 - int'(x[30:23]);
            sbig = 1'b0;
        end else begin
            m1 = {1'b1, x[22:0], 3'b000};
            m2 = {1'b1, 23'h0, 3'b000};
            e = int'(x[30:23]);
            d = int'(x[30:23]) - 127;
            sbig = xs;
        end
        if (d >= 27) begin
            sm = 27'd1;
        end else begin
            mask = (27'd1 << d) - 27'd1;
            sm = (m2 >> d) | 27'((m2 & mask) != 27'd0);
        end
        if (!xs) r = {1'b0, m1} + {1'b0, sm};
        else r = {1'b0, m1} - {1'b0, sm};
        if (r[27]) begin
            r = {1'b0, r[27:1]} | {27'd0, r[0]};
            e = e + 1;
        end
        for (int k = 0; k < 26; k++) begin
            if (!r[26] && r != 28'd0) begin
                r = r << 1;
                e = e - 1;
            end
        end
        mant = r[26:3];
        rnd = {1'b0, mant} + 25'(r[2] && (r[1] || r[0] || mant[0]));
        if (rnd[24]) begin
            mant = rnd[24:1];
            e = e + 1;
        end else begin
            mant = rnd[23:0];
        end
        if (f_nan(x)) res = f_snan(x) ? (x | 32'h0040_0000) : x;
        else if (f_inf(x)) res = {~x[31], 31'h7F80_0000};
        else if (f_zero(x)) res = F_ONE;
        else if (r == 28'd0) res = 32'h0;
        else res = {sbig, 8'(e), mant[22:0]};
        return res;
    endfunction

    // reciprocal square root estimate; finite non-zero inputs are always normal here
    function automatic logic [31:0] f_rsqrte(input logic [31:0] v);
        logic [8:0]  sc;
        logic [8:0]  rexp;
        logic [31:0] res;
        sc = v[23] ? {2'b01, v[22:16]} : {1'b1, v[22:15]};
        rexp = (9'd380 - {1'b0, v[30:23]}) >> 1;
        if (f_nan(v)) res = v | 32'h0040_0000;
        else if (f_zero(v)) res = {v[31], 31'h7F80_0000};
        else if (v[31]) res = F_DNAN;
        else if (v == F_PINF) res = 32'h0;
        else res = {1'b0, rexp[7:0], RS_TABLE[sc], 15'h0000};
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/hfvd_lane.sv =====
// one lane: difference stage and binary16 multiply-add accumulators
`default_nettype none
module hfvd_lane (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  hfvd_pkg::lane_ctl_t   ctl,
    input  wire  [15:0]           lane_a,
    input  wire  [15:0]           lane_b,
    input  wire                   lane_act,
    output logic [15:0]           acc_ab,
    output logic [15:0]           acc_a2,
    output logic [15:0]           acc_b2
);
    import hfvd_pkg::*;

    logic [15:0] a_reg;
    logic [15:0] b_reg;
    logic [15:0] d_reg;
    logic        act_reg;
    logic [15:0] ab_reg;
    logic [15:0] a2_reg;
    logic [15:0] b2_reg;
    logic [15:0] ab_next;
    logic [15:0] a2_next;
    logic [15:0] b2_next;
    logic [15:0] mul_x;
    logic [15:0] mul_y;

    // operands captured on the input beat, difference worked out alongside
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            a_reg <= lane_a;
            b_reg <= lane_b;
            d_reg <= h_sub(lane_a, lane_b);
        end
    end

    always_comb begin
        mul_x   = ctl.l2 ? d_reg : a_reg;
        mul_y   = ctl.l2 ? d_reg : b_reg;
        ab_next = h_fma(ab_reg, mul_x, mul_y);
        a2_next = h_fma(a2_reg, a_reg, a_reg);
        b2_next = h_fma(b2_reg, b_reg, b_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
            ab_reg  <= 16'h0000;
            a2_reg  <= 16'h0000;
            b2_reg  <= 16'h0000;
        end else begin
            if (ctl.load) act_reg <= lane_act;
            if (ctl.clr) begin
                ab_reg <= 16'h0000;
                a2_reg <= 16'h0000;
                b2_reg <= 16'h0000;
            end else if (ctl.acc && act_reg) begin
                ab_reg <= ab_next;
                if (ctl.cosine) begin
                    a2_reg <= a2_next;
                    b2_reg <= b2_next;
                end
            end
        end
    end

    assign acc_ab = ab_reg;
    assign acc_a2 = a2_reg;
    assign acc_b2 = b2_reg;

endmodule
`default_nettype wire

// ===== hdl/hfvd_reduce.sv =====
// merge stage: pairwise lane tree and the binary32 finishing sequence
`default_nettype none
module hfvd_reduce (
    input  wire                                         aclk,
    input  wire                                         aresetn,
    input  wire                                         start,
    input  wire  [1:0]                                  mode,
    input  wire  [hfvd_pkg::LANE_COUNT-1:0][15:0]       ab_lanes,
    input  wire  [hfvd_pkg::LANE_COUNT-1:0][15:0]       a2_lanes,
    input  wire  [hfvd_pkg::LANE_COUNT-1:0][15:0]       b2_lanes,
    output logic                                        done,
    output logic [31:0]                                 result
);
    import hfvd_pkg::*;

    localparam logic [2:0] STEP_WIDEN = 3'(TREE_LEVELS);
    localparam logic [2:0] STEP_RSQ   = STEP_WIDEN + 3'd1;
    localparam logic [2:0] STEP_MUL1  = STEP_WIDEN + 3'd2;
    localparam logic [2:0] STEP_MUL2  = STEP_WIDEN + 3'd3;
    localparam logic [2:0] STEP_FIN   = STEP_WIDEN + 3'd4;

    logic [LANE_COUNT-1:0][15:0] ab_reg;
    logic [LANE_COUNT-1:0][15:0] a2_reg;
    logic [LANE_COUNT-1:0][15:0] b2_reg;
    logic [2:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [1:0]  mode_reg;
    logic [31:0] wab_reg;
    logic [31:0] wa2_reg;
    logic [31:0] wb2_reg;
    logic [31:0] ra_reg;
    logic [31:0] rb_reg;
    logic [31:0] m1_reg;
    logic [31:0] m2_reg;
    logic [31:0] result_reg;
    logic        cosine;

    assign cosine = (mode_reg == MODE_COS) || (mode_reg == MODE_UNUSED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == STEP_FIN) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one tree level per step, upper halves go stale and are not read again
    always_ff @(posedge aclk) begin
        if (start) begin
            ab_reg   <= ab_lanes;
            a2_reg   <= a2_lanes;
            b2_reg   <= b2_lanes;
            mode_reg <= mode;
        end else if (busy_reg) begin
            if (step_reg < STEP_WIDEN) begin
                for (int i = 0; i < LANE_COUNT / 2; i++) begin
                    ab_reg[i] <= h_add(ab_reg[2*i], ab_reg[2*i+1]);
                    a2_reg[i] <= h_add(a2_reg[2*i], a2_reg[2*i+1]);
                    b2_reg[i] <= h_add(b2_reg[2*i], b2_reg[2*i+1]);
                end
            end
            case (step_reg)
                STEP_WIDEN: begin
                    wab_reg <= h_widen(ab_reg[0]);
                    wa2_reg <= h_widen(a2_reg[0]);
                    wb2_reg <= h_widen(b2_reg[0]);
                end
                STEP_RSQ: begin
                    ra_reg <= f_rsqrte(wa2_reg);
                    rb_reg <= f_rsqrte(wb2_reg);
                end
                STEP_MUL1: m1_reg <= f_mul(wab_reg, ra_reg);
                STEP_MUL2: m2_reg <= f_mul(m1_reg, rb_reg);
                STEP_FIN: begin
                    if (mode_reg == MODE_L2) result_reg <= wab_reg;
                    else if (cosine) result_reg <= f_one_minus(m2_reg);
                    else result_reg <= f_one_minus(wab_reg);
                end
                default: ;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== hdl/half_float_vector_distance.sv =====
// top level: binary16 vector distance over eight parallel lanes with a binary32 result
//
// Streams chunks of eight binary16 pairs and accumulates, per lane, (a-b)^2
// (metric_mode 0), a*b (mode 1) or a*b, a*a and b*b (modes 2 and 3, cosine),
// each with a single-rounded binary16 multiply-add. Lanes at or above
// valid_lanes (saturated at eight) hold their sums. A chunk with last_chunk set
// folds the lanes in a pairwise binary16 tree as it clears them, and returns
// one binary32 beat: the sum, 1 - sum, or 1 - ab*rsqrte(a2)*rsqrte(b2).
// In the accept cycle every lane captures its operands and forms a-b; the next
// runs the lane multiply-add, during which no new chunk is taken. A final
// chunk then hands the sums to the merge sequencer (three tree levels, widen,
// estimate, two multiplies, subtract); its done flag moves the top level to
// the output state, which loads the output register once it is free. The
// output register parts the two sides: new chunks are taken while a result
// beat waits. The user must see that metric_mode is written through the cfg
// port only while the block is idle; the block itself does not enforce this.
`default_nettype none
module half_float_vector_distance (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_metric_mode,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [63:0] s_a_lanes_low,
    input  wire  [63:0] s_a_lanes_high,
    input  wire  [63:0] s_b_lanes_low,
    input  wire  [63:0] s_b_lanes_high,
    input  wire  [3:0]  s_valid_lanes,
    input  wire         s_last_chunk,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_distance_bits
);
    import hfvd_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    logic [1:0]  mode_reg;
    logic [1:0]  item_mode_reg;
    logic        last_reg;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [31:0] out_reg;
    logic        s_accept;
    logic        red_start;
    logic        out_load;
    logic        red_done;
    logic [31:0] red_result;
    logic [3:0]  lane_count;
    lane_ctl_t   lane_ctl;

    logic [16*LANE_COUNT-1:0]    a_all;
    logic [16*LANE_COUNT-1:0]    b_all;
    logic [LANE_COUNT-1:0][15:0] ab_vec;
    logic [LANE_COUNT-1:0][15:0] a2_vec;
    logic [LANE_COUNT-1:0][15:0] b2_vec;

    // config register, always ready; the user must see that writes only land while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IP;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= cfg_metric_mode;
        end
    end

    assign s_accept   = s_valid && s_ready;
    assign lane_count = (s_valid_lanes > 4'(LANE_COUNT)) ? 4'(LANE_COUNT) : s_valid_lanes;
    assign a_all      = {s_a_lanes_high, s_a_lanes_low};
    assign b_all      = {s_b_lanes_high, s_b_lanes_low};

    // mode and last flag of the chunk in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_mode_reg <= MODE_IP;
            last_reg      <= 1'b0;
        end else if (s_accept) begin
            item_mode_reg <= mode_reg;
            last_reg      <= s_last_chunk;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_ACC;
            ST_ACC:  state_next = last_reg ? ST_LOAD : ST_IDLE;
            ST_LOAD: state_next = ST_RED;
            ST_RED:  if (red_done) state_next = ST_OUT;
            ST_OUT:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready         = 1'b0;
        red_start       = 1'b0;
        out_load        = 1'b0;
        lane_ctl.load   = 1'b0;
        lane_ctl.acc    = 1'b0;
        lane_ctl.clr    = 1'b0;
        lane_ctl.l2     = (item_mode_reg == MODE_L2);
        lane_ctl.cosine = (item_mode_reg == MODE_COS) || (item_mode_reg == MODE_UNUSED);
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                lane_ctl.load = s_valid;
            end
            ST_ACC:  lane_ctl.acc = 1'b1;
            ST_LOAD: begin
                red_start    = 1'b1;
                lane_ctl.clr = 1'b1;
            end
            ST_RED:  ;
            ST_OUT:  out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // the lanes
    for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
        hfvd_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (lane_ctl),
            .lane_a   (a_all[16*i +: 16]),
            .lane_b   (b_all[16*i +: 16]),
            .lane_act (4'(i) < lane_count),
            .acc_ab   (ab_vec[i]),
            .acc_a2   (a2_vec[i]),
            .acc_b2   (b2_vec[i])
        );
    end

    // merge stage, samples the sums on the same edge that clears the lanes
    hfvd_reduce u_reduce (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (red_start),
        .mode     (item_mode_reg),
        .ab_lanes (ab_vec),
        .a2_lanes (a2_vec),
        .b2_lanes (b2_vec),
        .done     (red_done),
        .result   (red_result)
    );

    // result beat register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) out_reg <= red_result;
    end

    assign m_valid         = m_valid_reg;
    assign m_distance_bits = out_reg;

`ifndef SYNTH
    // a result beat only appears out of the output state
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_OUT)
        else $error("result beat without a finished reduction");

    // merge stage finishes only while the sequencer waits for it
    a_done_in_red: assert property (@(posedge aclk) disable iff (!aresetn)
        red_done |-> state_reg == ST_RED)
        else $error("reduction finished outside the wait state");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_distance_bits)))
        else $error("pending result beat overwritten");
`endif

endmodule
`default_nettype wire
